### src/assert_macros.svh
// Assertion macros shared by the parser modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Check that a condition is followed by a consequence on the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/mrlp_pkg.sv
// Types and constants of the modem response line parser
package mrlp_pkg;

    localparam logic [7:0] LINE_FEED  = 8'h0A;
    localparam logic [7:0] ASCII_ZERO = 8'd48;
    localparam logic [7:0] ASCII_COMMA = 8'h2C;
    localparam logic [7:0] DIGIT_SCALE = 8'd10;
    localparam logic [3:0] PAD_DIGIT  = 4'hF;

    localparam int HEAD_BYTES   = 16;
    localparam int HEAD_W       = 8 * HEAD_BYTES;
    localparam int VIEW_BYTES   = 22;
    localparam int DIGIT_FIRST  = 9;
    localparam int DIGIT_COUNT  = 13;
    localparam int SQ_HI_POS    = 6;
    localparam int SQ_LO_POS    = 7;
    localparam int SQ_COMMA_A   = 7;
    localparam int SQ_COMMA_B   = 8;
    localparam int CENTER_W     = 56;
    localparam int Q_DEPTH      = 2;

    localparam logic [8*12-1:0] PFX_CPIN_READY = "+CPIN: READY";
    localparam logic [8*16-1:0] PFX_CPIN_NOT   = "+CPIN: NOT READY";
    localparam logic [8*11-1:0] PFX_CME_ERROR  = "+CME ERROR:";
    localparam logic [8*10-1:0] PFX_CREG_HOME  = "+CREG: 0,1";
    localparam logic [8*10-1:0] PFX_CREG_ROAM  = "+CREG: 0,5";
    localparam logic [8*2-1:0]  PFX_OK         = "OK";
    localparam logic [8*6-1:0]  PFX_CSQ        = "+CSQ: ";
    localparam logic [8*8-1:0]  PFX_RECEIVED   = "received";
    localparam logic [8*15-1:0] PFX_ALREADY    = "ALREADY CONNECT";
    localparam logic [8*6-1:0]  PFX_CMGS       = "+CMGS:";
    localparam logic [8*9-1:0]  PFX_CSCA       = "+CSCA: \"+";

    typedef struct packed {
        logic                        sim_ready;
        logic                        sim_absent;
        logic                        net_registered;
        logic                        ok_seen;
        logic                        csq_line;
        logic                        comma_a;
        logic                        comma_b;
        logic                        received_seen;
        logic                        already_connected;
        logic                        sms_sent;
        logic                        csca_line;
        logic [7:0]                  sq_hi;
        logic [7:0]                  sq_lo;
        logic [DIGIT_COUNT-1:0][3:0] digits;
    } t_line_rec;

    typedef struct packed {
        logic                sim_ready;
        logic                sim_absent;
        logic                net_registered;
        logic                ok_seen;
        logic                signal_valid;
        logic [7:0]          signal_strength;
        logic                received_seen;
        logic                already_connected;
        logic                sms_sent;
        logic                center_valid;
        logic [CENTER_W-1:0] center_number;
    } t_result;

endpackage

### src/modem_response_line_parser.sv
// Top level of the modem response line parser
//
//  channel   dir  handshake         payload
//  request   in   i_push / o_full   i_rx_byte
//  result    out  o_empty / i_pop   o_sim_ready .. o_center_number
//
// One byte is taken per cycle while the line queue is not full; a line feed's
// result passes through the line queue and then the result register.
// The front stalls only when the two-entry line queue is full; the back
// stalls while the result register waits on i_pop.
// Reset is synchronous and clears the line store, position, queue and result valid flag.
module modem_response_line_parser #(
    parameter int WRAP_LENGTH  = 1024,
    parameter int STORED_BYTES = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [7:0]  i_rx_byte,
    output logic        o_full,
    input  logic        i_pop,
    output logic        o_empty,
    output logic        o_sim_ready,
    output logic        o_sim_absent,
    output logic        o_net_registered,
    output logic        o_ok_seen,
    output logic        o_signal_valid,
    output logic [7:0]  o_signal_strength,
    output logic        o_received_seen,
    output logic        o_already_connected,
    output logic        o_sms_sent,
    output logic        o_center_valid,
    output logic [55:0] o_center_number
);

    logic                w_q_full;
    logic                w_q_push;
    mrlp_pkg::t_line_rec w_q_in;
    logic                w_q_valid;
    logic                w_q_pop;
    mrlp_pkg::t_line_rec w_q_out;
    mrlp_pkg::t_result   w_res;

    mrlp_front #(
        .WRAP_LENGTH  (WRAP_LENGTH),
        .STORED_BYTES (STORED_BYTES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (i_push),
        .i_rx_byte (i_rx_byte),
        .o_full    (o_full),
        .i_q_full  (w_q_full),
        .o_q_push  (w_q_push),
        .o_q_rec   (w_q_in)
    );

    mrlp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_rec   (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_rec   (w_q_out)
    );

    mrlp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (w_q_valid),
        .i_rec       (w_q_out),
        .o_rec_pop   (w_q_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_res       (w_res)
    );

    assign o_sim_ready         = w_res.sim_ready;
    assign o_sim_absent        = w_res.sim_absent;
    assign o_net_registered    = w_res.net_registered;
    assign o_ok_seen           = w_res.ok_seen;
    assign o_signal_valid      = w_res.signal_valid;
    assign o_signal_strength   = w_res.signal_strength;
    assign o_received_seen     = w_res.received_seen;
    assign o_already_connected = w_res.already_connected;
    assign o_sms_sent          = w_res.sms_sent;
    assign o_center_valid      = w_res.center_valid;
    assign o_center_number     = w_res.center_number;

endmodule

### src/mrlp_front.sv
// Line store, position counter and prefix classification of each line
`include "assert_macros.svh"

module mrlp_front #(
    parameter int WRAP_LENGTH  = 1024,
    parameter int STORED_BYTES = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [7:0]          i_rx_byte,
    output logic                o_full,
    input  logic                i_q_full,
    output logic                o_q_push,
    output mrlp_pkg::t_line_rec o_q_rec
);

    localparam int POSW = $clog2(WRAP_LENGTH);
    localparam int IDXW = $clog2(STORED_BYTES);
    localparam int SW   = $clog2(STORED_BYTES + 1);
    localparam int CW   = (POSW > SW) ? POSW : SW;

    logic [STORED_BYTES-1:0][7:0] r_store;
    logic [STORED_BYTES-1:0][7:0] n_store;
    logic [POSW-1:0]              r_pos;
    logic [POSW-1:0]              n_pos;

    logic [CW-1:0]                        w_pos_ext;
    logic                                 w_in_store;
    logic [IDXW-1:0]                      w_idx;
    logic                                 w_take;
    logic                                 w_newline;
    logic [mrlp_pkg::VIEW_BYTES-1:0][7:0] w_view;
    logic [mrlp_pkg::HEAD_W-1:0]          w_head;

    assign w_pos_ext  = CW'(r_pos);
    assign w_in_store = (w_pos_ext < CW'(STORED_BYTES));
    assign w_idx      = w_pos_ext[IDXW-1:0];
    assign w_take     = i_push && !i_q_full;
    assign w_newline  = (i_rx_byte == mrlp_pkg::LINE_FEED);
    assign o_full     = i_q_full;
    assign o_q_push   = w_take && w_newline;

    always_comb begin
        for (int k = 0; k < mrlp_pkg::VIEW_BYTES; k++) begin
            if (w_in_store && (w_idx == IDXW'(k))) begin
                w_view[k] = i_rx_byte;
            end else begin
                w_view[k] = r_store[k];
            end
        end
        for (int k = 0; k < mrlp_pkg::HEAD_BYTES; k++) begin
            w_head[mrlp_pkg::HEAD_W-1-8*k -: 8] = w_view[k];
        end
    end

    always_comb begin
        o_q_rec = '0;
        o_q_rec.sim_ready =
            (w_head[mrlp_pkg::HEAD_W-1 -: $bits(mrlp_pkg::PFX_CPIN_READY)]
                == mrlp_pkg::PFX_CPIN_READY);
        o_q_rec.sim_absent =
            (w_head[mrlp_pkg::HEAD_W-1 -: $bits(mrlp_pkg::PFX_CPIN_NOT)]
                == mrlp_pkg::PFX_CPIN_NOT) ||
            (w_head[mrlp_pkg::HEAD_W-1 -: $bits(mrlp_pkg::PFX_CME_ERROR)]
                == mrlp_pkg::PFX_CME_ERROR);
        o_q_rec.net_registered =
            (w_head[mrlp_pkg::HEAD_W-1 -: $bits(mrlp_pkg::PFX_CREG_HOME)]
                == mrlp_pkg::PFX_CREG_HOME) ||
            (w_head[mrlp_pkg::HEAD_W-1 -: $bits(mrlp_pkg::PFX_CREG_ROAM)]
                == mrlp_pkg::PFX_CREG_ROAM);
        o_q_rec.ok_seen =
            (w_head[mrlp_pkg::HEAD_W-1 -: $bits(mrlp_pkg::PFX_OK)] == mrlp_pkg::PFX_OK);
        o_q_rec.csq_line =
            (w_head[mrlp_pkg::HEAD_W-1 -: $bits(mrlp_pkg::PFX_CSQ)] == mrlp_pkg::PFX_CSQ);
        o_q_rec.comma_a = (w_view[mrlp_pkg::SQ_COMMA_A] == mrlp_pkg::ASCII_COMMA);
        o_q_rec.comma_b = (w_view[mrlp_pkg::SQ_COMMA_B] == mrlp_pkg::ASCII_COMMA);
        o_q_rec.received_seen =
            (w_head[mrlp_pkg::HEAD_W-1 -: $bits(mrlp_pkg::PFX_RECEIVED)]
                == mrlp_pkg::PFX_RECEIVED);
        o_q_rec.already_connected =
            (w_head[mrlp_pkg::HEAD_W-1 -: $bits(mrlp_pkg::PFX_ALREADY)]
                == mrlp_pkg::PFX_ALREADY);
        o_q_rec.sms_sent =
            (w_head[mrlp_pkg::HEAD_W-1 -: $bits(mrlp_pkg::PFX_CMGS)] == mrlp_pkg::PFX_CMGS);
        o_q_rec.csca_line =
            (w_head[mrlp_pkg::HEAD_W-1 -: $bits(mrlp_pkg::PFX_CSCA)] == mrlp_pkg::PFX_CSCA);
        o_q_rec.sq_hi = w_view[mrlp_pkg::SQ_HI_POS];
        o_q_rec.sq_lo = w_view[mrlp_pkg::SQ_LO_POS];
        for (int k = 0; k < mrlp_pkg::DIGIT_COUNT; k++) begin
            o_q_rec.digits[k] = w_view[mrlp_pkg::DIGIT_FIRST + k][3:0];
        end
    end

    always_comb begin
        n_store = r_store;
        n_pos   = r_pos;
        if (w_take) begin
            if (w_newline) begin
                n_store = '0;
                n_pos   = '0;
            end else begin
                if (w_in_store) begin
                    n_store[w_idx] = i_rx_byte;
                end
                if (r_pos == POSW'(WRAP_LENGTH - 1)) begin
                    n_pos = '0;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store <= '0;
            r_pos   <= '0;
        end else begin
            r_store <= n_store;
            r_pos   <= n_pos;
        end
    end

    `ASSERT_NEXT(a_newline_rewinds, i_clk, i_rst_n, o_q_push, (r_pos == '0) && (r_store == '0), "line end did not rewind the line store")
    `ASSERT_ALWAYS(a_pos_in_range, i_clk, i_rst_n, (r_pos <= POSW'(WRAP_LENGTH - 1)), "line position past wrap length")

endmodule

### src/mrlp_queue.sv
// Short queue of classified lines between front and back
`include "assert_macros.svh"

module mrlp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mrlp_pkg::t_line_rec i_rec,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output mrlp_pkg::t_line_rec o_rec
);

    localparam int PW = (mrlp_pkg::Q_DEPTH > 1) ? $clog2(mrlp_pkg::Q_DEPTH) : 1;
    localparam int NW = $clog2(mrlp_pkg::Q_DEPTH + 1);

    mrlp_pkg::t_line_rec r_slot [mrlp_pkg::Q_DEPTH];
    logic [PW-1:0]       r_wr_ptr;
    logic [PW-1:0]       n_wr_ptr;
    logic [PW-1:0]       r_rd_ptr;
    logic [PW-1:0]       n_rd_ptr;
    logic [NW-1:0]       r_count;
    logic [NW-1:0]       n_count;
    logic                w_wr;
    logic                w_rd;

    assign o_full  = (r_count == NW'(mrlp_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_slot[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PW'(mrlp_pkg::Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PW'(mrlp_pkg::Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slot[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, (r_count <= NW'(mrlp_pkg::Q_DEPTH)), "queue count past depth")
    `ASSERT_NEXT(a_count_grows, i_clk, i_rst_n, w_wr && !w_rd, r_count == $past(r_count) + 1'b1, "queue count did not grow on write")

endmodule

### src/mrlp_back.sv
// Signal quality and service center decode with the result register
`include "assert_macros.svh"

module mrlp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rec_valid,
    input  mrlp_pkg::t_line_rec i_rec,
    output logic                o_rec_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output mrlp_pkg::t_result   o_res
);

    logic                r_valid;
    logic                n_valid;
    mrlp_pkg::t_result   r_res;
    mrlp_pkg::t_result   n_res;
    logic [7:0]          w_hi;
    logic [7:0]          w_lo;
    logic [7:0]          w_tens;
    logic [7:0]          w_sig;
    logic [mrlp_pkg::CENTER_W-1:0] w_center;
    logic [3:0]          w_even;
    logic [3:0]          w_odd;

    assign o_empty   = !r_valid;
    assign o_res     = r_res;
    assign o_rec_pop = i_rec_valid && (!r_valid || i_pop);

    assign w_hi   = i_rec.sq_hi - mrlp_pkg::ASCII_ZERO;
    assign w_lo   = i_rec.sq_lo - mrlp_pkg::ASCII_ZERO;
    assign w_tens = 8'(w_hi * mrlp_pkg::DIGIT_SCALE);

    always_comb begin
        w_sig = '0;
        if (i_rec.csq_line) begin
            priority if (i_rec.comma_b) begin
                w_sig = w_tens + w_lo;
            end else if (i_rec.comma_a) begin
                w_sig = w_hi;
            end
        end
    end

    always_comb begin
        w_center = '0;
        w_even   = '0;
        w_odd    = '0;
        for (int j = 0; j < (mrlp_pkg::DIGIT_COUNT + 1) / 2; j++) begin
            w_even = i_rec.digits[2*j];
            if (2*j + 1 < mrlp_pkg::DIGIT_COUNT) begin
                w_odd = i_rec.digits[2*j + 1];
            end else begin
                w_odd = mrlp_pkg::PAD_DIGIT;
            end
            w_center[mrlp_pkg::CENTER_W-1-8*j -: 8] = {w_odd, w_even};
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_res   = r_res;
        if (o_rec_pop) begin
            n_valid                 = 1'b1;
            n_res.sim_ready         = i_rec.sim_ready;
            n_res.sim_absent        = i_rec.sim_absent;
            n_res.net_registered    = i_rec.net_registered;
            n_res.ok_seen           = i_rec.ok_seen;
            n_res.signal_valid      = i_rec.csq_line && (i_rec.comma_a || i_rec.comma_b);
            n_res.signal_strength   = w_sig;
            n_res.received_seen     = i_rec.received_seen;
            n_res.already_connected = i_rec.already_connected;
            n_res.sms_sent          = i_rec.sms_sent;
            n_res.center_valid      = i_rec.csca_line;
            n_res.center_number     = i_rec.csca_line ? w_center : '0;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    `ASSERT_NEXT(a_load_fills, i_clk, i_rst_n, o_rec_pop, r_valid, "result register not loaded")

endmodule

### sim/mrlp_checker.sv
// Line decode predictor and result scoreboard for the modem response line parser
`timescale 1ns / 1ps

module mrlp_checker #(
    parameter int WRAP_LENGTH  = 1024,
    parameter int STORED_BYTES = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_full,
    input  logic        i_pop,
    input  logic        i_empty,
    input  logic        i_sim_ready,
    input  logic        i_sim_absent,
    input  logic        i_net_registered,
    input  logic        i_ok_seen,
    input  logic        i_signal_valid,
    input  logic [7:0]  i_signal_strength,
    input  logic        i_received_seen,
    input  logic        i_already_connected,
    input  logic        i_sms_sent,
    input  logic        i_center_valid,
    input  logic [55:0] i_center_number,
    output int          o_fail_count,
    output int          o_pending
);

    logic [7:0]        line_bytes [STORED_BYTES];
    int unsigned       line_pos;
    mrlp_pkg::t_result line_reports_due [$];

    task automatic note_failure(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input logic [55:0] got,
                               input logic [55:0] want);
        if (got !== want) begin
            note_failure($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    function automatic logic [7:0] byte_at(input int k);
        return (k < STORED_BYTES) ? line_bytes[k] : 8'h00;
    endfunction

    function automatic logic [3:0] nibble_at(input int k);
        logic [7:0] d;
        d = byte_at(k) - mrlp_pkg::ASCII_ZERO;
        return d[3:0];
    endfunction

    function automatic bit line_starts(input string p);
        for (int n = 0; n < p.len(); n++) begin
            if (n >= STORED_BYTES || line_bytes[n] != p[n]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic mrlp_pkg::t_result decode_line();
        mrlp_pkg::t_result r;
        logic [7:0]        hi_d;
        logic [7:0]        lo_d;
        logic [55:0]       num;
        r = '0;
        if (line_starts("+CSQ: ")) begin
            hi_d = byte_at(mrlp_pkg::SQ_HI_POS) - mrlp_pkg::ASCII_ZERO;
            lo_d = byte_at(mrlp_pkg::SQ_LO_POS) - mrlp_pkg::ASCII_ZERO;
            if (byte_at(mrlp_pkg::SQ_COMMA_A) == mrlp_pkg::ASCII_COMMA) begin
                r.signal_valid    = 1'b1;
                r.signal_strength = hi_d;
            end
            if (byte_at(mrlp_pkg::SQ_COMMA_B) == mrlp_pkg::ASCII_COMMA) begin
                r.signal_valid    = 1'b1;
                r.signal_strength = hi_d * mrlp_pkg::DIGIT_SCALE + lo_d;
            end
        end
        if (line_starts("+CSCA: \"+")) begin
            num = '0;
            for (int k = 0; k < 14; k += 2) begin
                num = {num[47:0],
                       (k + 1 < mrlp_pkg::DIGIT_COUNT)
                           ? nibble_at(mrlp_pkg::DIGIT_FIRST + 1 + k)
                           : mrlp_pkg::PAD_DIGIT,
                       nibble_at(mrlp_pkg::DIGIT_FIRST + k)};
            end
            r.center_valid  = 1'b1;
            r.center_number = num;
        end
        r.sim_ready         = line_starts("+CPIN: READY");
        r.sim_absent        = line_starts("+CPIN: NOT READY") || line_starts("+CME ERROR:");
        r.net_registered    = line_starts("+CREG: 0,1") || line_starts("+CREG: 0,5");
        r.ok_seen           = line_starts("OK");
        r.received_seen     = line_starts("received");
        r.already_connected = line_starts("ALREADY CONNECT");
        r.sms_sent          = line_starts("+CMGS:");
        return r;
    endfunction

    task automatic clear_line();
        for (int k = 0; k < STORED_BYTES; k++) line_bytes[k] = 8'h00;
        line_pos = 0;
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        if (line_pos < STORED_BYTES) line_bytes[line_pos] = b;
        if (b != mrlp_pkg::LINE_FEED) begin
            line_pos = (line_pos + 1) % WRAP_LENGTH;
        end else begin
            line_reports_due.push_back(decode_line());
            clear_line();
        end
    endtask

    task automatic compare_report();
        mrlp_pkg::t_result want;
        if (line_reports_due.size() == 0) begin
            note_failure("result with no line pending");
        end else begin
            want = line_reports_due.pop_front();
            check_field("sim_ready", i_sim_ready, want.sim_ready);
            check_field("sim_absent", i_sim_absent, want.sim_absent);
            check_field("net_registered", i_net_registered, want.net_registered);
            check_field("ok_seen", i_ok_seen, want.ok_seen);
            check_field("signal_valid", i_signal_valid, want.signal_valid);
            check_field("signal_strength", i_signal_strength, want.signal_strength);
            check_field("received_seen", i_received_seen, want.received_seen);
            check_field("already_connected", i_already_connected, want.already_connected);
            check_field("sms_sent", i_sms_sent, want.sms_sent);
            check_field("center_valid", i_center_valid, want.center_valid);
            check_field("center_number", i_center_number, want.center_number);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_line();
            line_reports_due.delete();
        end else begin
            if (i_pop && !i_empty) compare_report();
            if (i_push && !i_full) absorb_byte(i_rx_byte);
        end
        o_pending <= line_reports_due.size();
    end

endmodule

### sim/tb_top.sv
// Stimulus and verdict for the modem response line parser
`timescale 1ns / 1ps

module tb_top;

    localparam int WRAP_LENGTH  = 1024;
    localparam int STORED_BYTES = 24;
    localparam int PHASE_BYTES  = 30;
    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 16;
    localparam int HEAD_CSQ     = 6;
    localparam int HEAD_CSCA    = 10;
    localparam int HEAD_LAST    = 10;
    localparam logic [7:0] CARRIAGE = 8'h0D;

    typedef enum int {
        LINE_WELL_FORMED,
        LINE_BROKEN,
        LINE_NOISE,
        LINE_EMPTY
    } t_line_kind;

    logic        i_clk;
    logic        i_rst_n   = 1'b0;
    logic        i_push    = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_pop     = 1'b0;
    logic        o_full;
    logic        o_empty;
    logic        o_sim_ready;
    logic        o_sim_absent;
    logic        o_net_registered;
    logic        o_ok_seen;
    logic        o_signal_valid;
    logic [7:0]  o_signal_strength;
    logic        o_received_seen;
    logic        o_already_connected;
    logic        o_sms_sent;
    logic        o_center_valid;
    logic [55:0] o_center_number;

    int fail_count;
    int pending_count;
    int send_idle_pct = 15;
    int recv_idle_pct = 66;
    int bytes_sent    = 0;
    int stall_cycles  = 0;
    bit hold_request  = 1'b0;
    bit hold_served   = 1'b0;

    modem_response_line_parser #(
        .WRAP_LENGTH (WRAP_LENGTH),
        .STORED_BYTES(STORED_BYTES)
    ) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (i_push),
        .i_rx_byte          (i_rx_byte),
        .o_full             (o_full),
        .i_pop              (i_pop),
        .o_empty            (o_empty),
        .o_sim_ready        (o_sim_ready),
        .o_sim_absent       (o_sim_absent),
        .o_net_registered   (o_net_registered),
        .o_ok_seen          (o_ok_seen),
        .o_signal_valid     (o_signal_valid),
        .o_signal_strength  (o_signal_strength),
        .o_received_seen    (o_received_seen),
        .o_already_connected(o_already_connected),
        .o_sms_sent         (o_sms_sent),
        .o_center_valid     (o_center_valid),
        .o_center_number    (o_center_number)
    );

    mrlp_checker #(
        .WRAP_LENGTH (WRAP_LENGTH),
        .STORED_BYTES(STORED_BYTES)
    ) i_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (i_push),
        .i_rx_byte          (i_rx_byte),
        .i_full             (o_full),
        .i_pop              (i_pop),
        .i_empty            (o_empty),
        .i_sim_ready        (o_sim_ready),
        .i_sim_absent       (o_sim_absent),
        .i_net_registered   (o_net_registered),
        .i_ok_seen          (o_ok_seen),
        .i_signal_valid     (o_signal_valid),
        .i_signal_strength  (o_signal_strength),
        .i_received_seen    (o_received_seen),
        .i_already_connected(o_already_connected),
        .i_sms_sent         (o_sms_sent),
        .i_center_valid     (o_center_valid),
        .i_center_number    (o_center_number),
        .o_fail_count       (fail_count),
        .o_pending          (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin : result_drain
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_served) begin
                hold_served = 1'b1;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_pop <= 1'b0;
            end else begin
                i_pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic string head_text(input int k);
        case (k)
            0:         return "+CPIN: READY";
            1:         return "+CPIN: NOT READY";
            2:         return "+CME ERROR:";
            3:         return "+CREG: 0,1";
            4:         return "+CREG: 0,5";
            5:         return "OK";
            HEAD_CSQ:  return "+CSQ: ";
            7:         return "received";
            8:         return "ALREADY CONNECT";
            9:         return "+CMGS:";
            default:   return "+CSCA: \"+";
        endcase
    endfunction

    function automatic logic [7:0] any_but_feed();
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        return (v == mrlp_pkg::LINE_FEED) ? 8'h00 : v;
    endfunction

    function automatic logic [7:0] pick_digit();
        if ($urandom_range(99) < 85) return mrlp_pkg::ASCII_ZERO + 8'($urandom_range(0, 9));
        return any_but_feed();
    endfunction

    function automatic logic [7:0] pick_text();
        if ($urandom_range(99) < 80) return 8'($urandom_range(8'h20, 8'h7E));
        return any_but_feed();
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < send_idle_pct) begin
            i_push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_push    <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int n = 0; n < s.len(); n++) send_byte(s[n]);
    endtask

    task automatic drain();
        i_push <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    task automatic push_head(ref logic [7:0] text [$], input int k);
        string s;
        s = head_text(k);
        for (int n = 0; n < s.len(); n++) text.push_back(s[n]);
    endtask

    task automatic send_response_line();
        logic [7:0] text [$];
        t_line_kind kind;
        int         roll;
        int         h;
        int         n;
        int         spot;
        roll = $urandom_range(99);
        kind = (roll < 70) ? LINE_WELL_FORMED : (roll < 85) ? LINE_BROKEN :
               (roll < 95) ? LINE_NOISE : LINE_EMPTY;
        h = $urandom_range(0, HEAD_LAST);
        case (kind)
            LINE_WELL_FORMED, LINE_BROKEN: begin
                push_head(text, h);
                if (h == HEAD_CSQ) begin
                    repeat ($urandom_range(1, 2)) text.push_back(pick_digit());
                    if ($urandom_range(99) < 85) text.push_back(mrlp_pkg::ASCII_COMMA);
                    repeat ($urandom_range(0, 3)) text.push_back(pick_digit());
                end else if (h == HEAD_CSCA) begin
                    n = ($urandom_range(99) < 90) ? mrlp_pkg::DIGIT_COUNT
                                                  : $urandom_range(0, mrlp_pkg::DIGIT_COUNT);
                    repeat (n) text.push_back(pick_digit());
                    text.push_back("\"");
                end
                if (kind == LINE_BROKEN) begin
                    spot = $urandom_range(0, text.size() - 1);
                    text[spot] = text[spot] ^ (8'h01 << $urandom_range(0, 7));
                    if (text[spot] == mrlp_pkg::LINE_FEED) text[spot] = 8'h00;
                end
                n = ($urandom_range(99) < 10) ? $urandom_range(10, 40) : $urandom_range(0, 8);
                repeat (n) text.push_back(pick_text());
                if ($urandom_range(99) < 80) text.push_back(CARRIAGE);
            end
            LINE_NOISE: begin
                repeat ($urandom_range(0, 40)) text.push_back(8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
        text.push_back(mrlp_pkg::LINE_FEED);
        foreach (text[i]) send_byte(text[i]);
    endtask

    task automatic run_directed();
        for (int k = 0; k <= HEAD_LAST; k++) send_text({head_text(k), "\015\n"});
        send_text("+CSQ: 9,99\n");
        send_text("+CSQ: 31,99\n");
        send_text("+CSQ: 123\n");
        send_text("+CSQ: 5,,\n");
        send_text("+CSQ: ");
        send_byte(8'hFF);
        send_byte(8'h00);
        send_text(",\n");
        send_text("+CSCA: \"+8613800200500\",145\015\n");
        send_text("+CSCA: \"+12\n");
        send_text("+CREG: 0,2\n");
        send_text("\n");
        send_text("O\n");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(mrlp_pkg::LINE_FEED);
        send_text("ALREADY CONNECT and a tail that runs well past the store\n");
        send_text("OK");
        repeat (WRAP_LENGTH - 2) send_byte(pick_text());
        send_text("+CMGS:\n");
    endtask

    initial begin : stimulus
        int start;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        drain();
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 66 : 0;
            recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 15 : 0;
            if (phase == 2) begin
                hold_request = 1'b1;
                send_text("\n\n\n\n");
            end
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES) send_response_line();
            drain();
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/mrlp_pkg.sv
src/mrlp_front.sv
src/mrlp_queue.sv
src/mrlp_back.sv
src/modem_response_line_parser.sv
sim/mrlp_checker.sv
sim/tb_top.sv
